### sv/csrs_pkg.sv
// Shared types, constants and register codes for the CAN session rate statistics block.
package csrs_pkg;

    localparam int MaxIds   = 64;
    localparam int FillW    = $clog2(MaxIds + 1);
    localparam int IdW      = 11;
    localparam int LenW     = 4;
    localparam int DataW    = 64;
    localparam int CntW     = 32;
    localparam int TimeW    = 48;
    localparam int MeanW    = 55;
    localparam int CodeW    = 16;
    localparam int CfgW     = 16;
    localparam int CfgIdxW  = 2;
    localparam int InTdW    = 128;
    localparam int OutTdW   = 104;
    localparam int OutTuW   = 2;
    localparam int MapDepth = 1 << IdW;
    localparam int DivCntW  = $clog2(MeanW + 1);

    localparam logic [IdW-1:0]   RstControlId = 11'h0A0;
    localparam logic [CodeW-1:0] RstStartA    = 16'h6601;
    localparam logic [CodeW-1:0] RstStartB    = 16'hFF01;
    localparam logic [CodeW-1:0] RstStop      = 16'h66FF;
    localparam logic [LenW-1:0]  CmdLen       = 4'd2;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_CONTROL_ID = 2'd0,
        CFG_START_A    = 2'd1,
        CFG_START_B    = 2'd2,
        CFG_STOP       = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_INIT, ST_CLR, ST_IDLE, ST_UPD, ST_DRD, ST_DCHK, ST_DSTART, ST_DWAIT, ST_DOUT
    } t_state;

    // One statistics record, stored at the address given by the identifier.
    typedef struct packed {
        logic             valid;
        logic [CntW-1:0]  count;
        logic [TimeW-1:0] first;
        logic [TimeW-1:0] last;
    } t_entry;

    typedef struct packed {
        logic cap_in;
        logic rd_in;
        logic rd_scan;
        logic upd;
        logic clr_scan;
        logic emit_load;
        logic div_start;
        logic scan_clr;
        logic scan_inc;
        logic emit_inc;
        logic session_clr;
    } t_cmd;

    typedef struct packed {
        logic is_start;
        logic is_stop;
        logic valid;
        logic cnt_ge2;
        logic last_rec;
        logic scan_end;
        logic div_done;
    } t_stat;

endpackage

### sv/csrs_div.sv
// Iterative restoring divider for the mean gap, one quotient bit a cycle, rounded half up.
module csrs_div
    import csrs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [TimeW-1:0] i_span,
    input  logic [CntW-1:0]  i_den,
    output logic             o_done,
    output logic [MeanW-1:0] o_quot
);

    logic               r_busy;
    logic               r_done;
    logic [DivCntW-1:0] r_cnt;
    logic [MeanW-1:0]   r_q;
    logic [CntW-1:0]    r_rem;
    logic [CntW-1:0]    r_den;
    logic [MeanW-1:0]   w_num;
    logic [CntW:0]      w_rem_sh;
    logic               w_qbit;
    logic               w_round;

    // Numerator is span times one hundred, built from shifts.
    assign w_num = {1'b0, i_span, 6'b0} + {2'b0, i_span, 5'b0} + {5'b0, i_span, 2'b0};

    assign w_rem_sh = {r_rem, r_q[MeanW-1]};
    assign w_qbit   = (w_rem_sh >= {1'b0, r_den});
    // Round up when twice the remainder reaches the divisor.
    assign w_round  = ({r_rem, 1'b0} >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == DivCntW'(MeanW)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= w_num;
            r_rem <= '0;
            r_den <= i_den;
            r_cnt <= '0;
        end else if (r_busy) begin
            if (r_cnt == DivCntW'(MeanW)) begin
                r_q <= r_q + MeanW'(w_round);
            end else begin
                r_q   <= {r_q[MeanW-2:0], w_qbit};
                r_rem <= w_qbit ? CntW'(w_rem_sh - {1'b0, r_den}) : w_rem_sh[CntW-1:0];
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

### sv/csrs_ctrl.sv
// Controller state machine: frame update, reset clearing pass and ordered dump.
module csrs_ctrl
    import csrs_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_tvalid,
    output logic  o_s_tready,
    output logic  o_m_tvalid,
    input  logic  i_m_tready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   r_rec, n_rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_rec   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rec   <= n_rec;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        n_rec      = r_rec;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        o_m_tvalid = 1'b0;
        case (r_state)
            ST_INIT: begin
                o_cmd.scan_clr = 1'b1;
                n_state        = ST_CLR;
            end
            ST_CLR: begin
                o_cmd.clr_scan = 1'b1;
                o_cmd.scan_inc = 1'b1;
                if (i_stat.scan_end) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_s_tready  = 1'b1;
                o_cmd.rd_in = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.cap_in = 1'b1;
                    if (i_stat.is_start && !r_rec) begin
                        n_rec   = 1'b1;
                        n_state = ST_UPD;
                    end else if (i_stat.is_stop && r_rec) begin
                        o_cmd.scan_clr = 1'b1;
                        n_state        = ST_DRD;
                    end else if (r_rec) begin
                        n_state = ST_UPD;
                    end
                end
            end
            ST_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = ST_IDLE;
            end
            ST_DRD: begin
                o_cmd.rd_scan = 1'b1;
                n_state       = ST_DCHK;
            end
            ST_DCHK: begin
                if (i_stat.valid) begin
                    o_cmd.emit_load = 1'b1;
                    o_cmd.clr_scan  = 1'b1;
                    n_state         = i_stat.cnt_ge2 ? ST_DSTART : ST_DOUT;
                end else begin
                    o_cmd.scan_inc = 1'b1;
                    n_state        = ST_DRD;
                end
            end
            ST_DSTART: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_DWAIT;
            end
            ST_DWAIT: begin
                if (i_stat.div_done) begin
                    n_state = ST_DOUT;
                end
            end
            ST_DOUT: begin
                o_m_tvalid = 1'b1;
                if (i_m_tready) begin
                    if (i_stat.last_rec) begin
                        o_cmd.session_clr = 1'b1;
                        n_rec             = 1'b0;
                        n_state           = ST_IDLE;
                    end else begin
                        o_cmd.scan_inc = 1'b1;
                        o_cmd.emit_inc = 1'b1;
                        n_state        = ST_DRD;
                    end
                end
            end
            default: begin
                n_state = ST_INIT;
            end
        endcase
    end

endmodule

### sv/csrs_dp.sv
// Datapath: configuration registers, identifier-addressed statistics memory and result registers.
module csrs_dp
    import csrs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [InTdW-1:0]   i_s_tdata,
    input  logic               i_cfg_we,
    input  logic [CfgIdxW-1:0] i_cfg_index,
    input  logic [CfgW-1:0]    i_cfg_data,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    output logic [OutTdW-1:0]  o_m_tdata,
    output logic [OutTuW-1:0]  o_m_tuser,
    output logic               o_m_tlast
);

    logic [IdW-1:0]   r_ctl_id;
    logic [CodeW-1:0] r_start_a, r_start_b, r_stop;

    logic [IdW-1:0]   w_in_id;
    logic [LenW-1:0]  w_in_len;
    logic [DataW-1:0] w_in_data;
    logic [TimeW-1:0] w_in_time;
    logic             w_is_cmd;

    t_entry           r_mem [MapDepth];
    t_entry           r_rd;
    t_entry           w_wdata;
    logic             w_we;
    logic [IdW-1:0]   w_raddr, w_waddr;
    logic             w_room;

    logic [IdW-1:0]   r_id;
    logic [TimeW-1:0] r_time;
    logic [IdW-1:0]   r_scan;
    logic [FillW-1:0] r_fill, r_emit;
    logic             r_ovf;

    logic [IdW-1:0]   r_out_id;
    logic [CntW-1:0]  r_out_cnt;
    logic [MeanW-1:0] r_out_mean;
    logic             r_out_mv, r_out_ovf, r_out_last;
    logic [TimeW-1:0] r_span;

    logic             w_div_done;
    logic [MeanW-1:0] w_div_quot;
    logic             w_last_rec;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_id  <= RstControlId;
            r_start_a <= RstStartA;
            r_start_b <= RstStartB;
            r_stop    <= RstStop;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_CONTROL_ID: r_ctl_id  <= i_cfg_data[IdW-1:0];
                CFG_START_A:    r_start_a <= i_cfg_data;
                CFG_START_B:    r_start_b <= i_cfg_data;
                CFG_STOP:       r_stop    <= i_cfg_data;
                default:        r_stop    <= r_stop;
            endcase
        end
    end

    // Input item fields and command decode.
    assign w_in_id   = i_s_tdata[10:0];
    assign w_in_len  = i_s_tdata[14:11];
    assign w_in_data = i_s_tdata[78:15];
    assign w_in_time = i_s_tdata[126:79];
    assign w_is_cmd  = (w_in_id == r_ctl_id) && (w_in_len == CmdLen);

    assign o_stat.is_start = w_is_cmd && ((w_in_data == {48'b0, r_start_a}) ||
                                          (w_in_data == {48'b0, r_start_b}));
    assign o_stat.is_stop  = w_is_cmd && (w_in_data == {48'b0, r_stop});

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_in) begin
            r_id   <= w_in_id;
            r_time <= w_in_time;
        end
    end

    // Statistics memory, one registered read and one write a cycle.
    assign w_raddr = i_cmd.rd_scan ? r_scan : w_in_id;
    assign w_room  = (r_fill < FillW'(MaxIds));
    assign w_we    = i_cmd.clr_scan || (i_cmd.upd && (r_rd.valid || w_room));
    assign w_waddr = i_cmd.upd ? r_id : r_scan;

    always_comb begin
        w_wdata = '0;
        if (i_cmd.upd) begin
            if (r_rd.valid) begin
                w_wdata.valid = 1'b1;
                w_wdata.count = (&r_rd.count) ? r_rd.count : r_rd.count + 1'b1;
                w_wdata.first = r_rd.first;
                w_wdata.last  = r_time;
            end else begin
                w_wdata.valid = 1'b1;
                w_wdata.count = CntW'(1);
                w_wdata.first = r_time;
                w_wdata.last  = r_time;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_in || i_cmd.rd_scan) begin
            r_rd <= r_mem[w_raddr];
        end
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
    end

    // Scan address for the clearing pass and the dump.
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_clr) begin
            r_scan <= '0;
        end else if (i_cmd.scan_inc) begin
            r_scan <= r_scan + 1'b1;
        end
    end

    // Fill count, emitted count and overflow flag of the session.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.session_clr) begin
            r_fill <= '0;
            r_emit <= '0;
            r_ovf  <= 1'b0;
        end else begin
            if (i_cmd.upd && !r_rd.valid) begin
                if (w_room) begin
                    r_fill <= r_fill + 1'b1;
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.emit_inc) begin
                r_emit <= r_emit + 1'b1;
            end
        end
    end

    assign w_last_rec = (r_emit == r_fill - 1'b1);

    // Result record registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_load) begin
            r_out_id   <= r_scan;
            r_out_cnt  <= r_rd.count;
            r_out_mean <= '0;
            r_out_mv   <= (r_rd.count >= CntW'(2));
            r_out_last <= w_last_rec;
            r_out_ovf  <= w_last_rec && r_ovf;
            r_span     <= (r_rd.last >= r_rd.first) ? r_rd.last - r_rd.first : '0;
        end else if (w_div_done) begin
            r_out_mean <= w_div_quot;
        end
    end

    csrs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_span  (r_span),
        .i_den   (r_out_cnt - 1'b1),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    assign o_stat.valid    = r_rd.valid;
    assign o_stat.cnt_ge2  = (r_rd.count >= CntW'(2));
    assign o_stat.last_rec = r_out_last;
    assign o_stat.scan_end = &r_scan;
    assign o_stat.div_done = w_div_done;

    assign o_m_tdata = {6'b0, r_out_mean, r_out_cnt, r_out_id};
    assign o_m_tuser = {r_out_ovf, r_out_mv};
    assign o_m_tlast = r_out_last;

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FillW'(MaxIds)) else $error("table fill count above capacity");
    a_emit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emit <= r_fill) else $error("more records emitted than stored");
    a_session_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.session_clr |=> (r_fill == '0) && !r_ovf)
        else $error("session state not cleared after dump");
`endif

endmodule

### sv/can_session_id_rate_stats.sv
// Top level: joins the controller and the datapath of the CAN session rate statistics block.
// An ordinary frame in a session is accepted with its memory read, then updated by a read-modify-write.
// A command frame that records nothing has no update step; a start frame is itself recorded like an ordinary frame.
// The dump walks identifiers from 0 upward, reading and checking each, and outputs each stored record,
// running the divider first for each record with two or more frames; no item is accepted meanwhile.
// After reset a clearing pass sweeps the whole memory before the first item.
module can_session_id_rate_stats
    import csrs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // can_id[10:0], data_len[14:11], data_value[78:15], time_ms[126:79], zero[127]
    input  logic [InTdW-1:0]   s_axis_tdata,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // stat_id[10:0], msg_count[42:11], mean_gap_x100[97:43], zero[103:98]
    output logic [OutTdW-1:0]  m_axis_tdata,
    // mean_valid[0], table_overflow[1]
    output logic [OutTuW-1:0]  m_axis_tuser,
    output logic               m_axis_tlast,
    input  logic               i_cfg_we,
    input  logic [CfgIdxW-1:0] i_cfg_index,
    input  logic [CfgW-1:0]    i_cfg_data
);

    t_cmd  w_cmd;
    t_stat w_stat;

    csrs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    csrs_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tdata   (s_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_m_tdata   (m_axis_tdata),
        .o_m_tuser   (m_axis_tuser),
        .o_m_tlast   (m_axis_tlast)
    );

endmodule

### tb/can_session_id_rate_stats_checker.sv
// Checker for the CAN session rate statistics block: predicts and compares dump records.
`timescale 1ns / 100ps
module can_session_id_rate_stats_checker
    import csrs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    input  logic               s_axis_tready,
    input  logic [InTdW-1:0]   s_axis_tdata,
    input  logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    input  logic [OutTdW-1:0]  m_axis_tdata,
    input  logic [OutTuW-1:0]  m_axis_tuser,
    input  logic               m_axis_tlast,
    input  logic               i_cfg_we,
    input  logic [CfgIdxW-1:0] i_cfg_index,
    input  logic [CfgW-1:0]    i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct {
        logic [IdW-1:0]   id;
        logic [CntW-1:0]  count;
        logic [MeanW-1:0] mean;
        logic             mean_ok;
        logic             ovf;
        logic             last;
    } t_record;

    // Predicted session state and registers.
    logic [IdW-1:0]   ctl_id;
    logic [CodeW-1:0] start_a, start_b, stop_c;
    logic             rec_on, ovf_seen;
    logic             tab_valid [MaxIds];
    logic [IdW-1:0]   tab_id [MaxIds];
    logic [CntW-1:0]  tab_cnt [MaxIds];
    logic [TimeW-1:0] tab_first [MaxIds];
    logic [TimeW-1:0] tab_last [MaxIds];
    t_record          expected_records [$];

    assign o_pending = expected_records.size();

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        o_fail_count++;
    endtask

    function automatic logic [MeanW-1:0] mean_gap(input int k);
        logic [63:0] span, num, den, q, r;
        span = (tab_last[k] < tab_first[k]) ? 64'd0 : 64'(tab_last[k] - tab_first[k]);
        num = span * 100;
        den = 64'(tab_cnt[k]) - 1;
        q = num / den;
        r = num % den;
        if (r >= den - r) q++;
        return q[MeanW-1:0];
    endfunction

    task automatic clear_sessions();
        for (int k = 0; k < MaxIds; k++) tab_valid[k] = 1'b0;
        ovf_seen = 1'b0;
    endtask

    task automatic log_frame(input logic [IdW-1:0] id, input logic [TimeW-1:0] t);
        int free_k;
        free_k = -1;
        for (int k = 0; k < MaxIds; k++) begin
            if (tab_valid[k] && tab_id[k] == id) begin
                if (tab_cnt[k] != '1) tab_cnt[k]++;
                tab_last[k] = t;
                return;
            end
            if (!tab_valid[k] && free_k < 0) free_k = k;
        end
        if (free_k < 0) begin
            ovf_seen = 1'b1;
            return;
        end
        tab_valid[free_k] = 1'b1;
        tab_id[free_k] = id;
        tab_cnt[free_k] = 1;
        tab_first[free_k] = t;
        tab_last[free_k] = t;
    endtask

    // Emit the table in ascending id order.
    task automatic dump_sessions();
        logic    taken [MaxIds];
        int      best, n;
        t_record rec;
        n = 0;
        for (int k = 0; k < MaxIds; k++) taken[k] = 1'b0;
        forever begin
            best = -1;
            for (int k = 0; k < MaxIds; k++)
                if (tab_valid[k] && !taken[k] && (best < 0 || tab_id[k] < tab_id[best]))
                    best = k;
            if (best < 0) break;
            taken[best] = 1'b1;
            rec.id = tab_id[best];
            rec.count = tab_cnt[best];
            rec.mean_ok = tab_cnt[best] >= 2;
            rec.mean = rec.mean_ok ? mean_gap(best) : '0;
            rec.ovf = 1'b0;
            rec.last = 1'b0;
            expected_records.insert(expected_records.size(), rec);
            n++;
        end
        if (n > 0) begin
            expected_records[$].ovf = ovf_seen;
            expected_records[$].last = 1'b1;
        end
    endtask

    task automatic predict_frame(input logic [InTdW-1:0] td);
        logic [IdW-1:0]   id;
        logic [LenW-1:0]  len;
        logic [DataW-1:0] data;
        logic [TimeW-1:0] t;
        logic             is_cmd;
        id = td[10:0];
        len = td[14:11];
        data = td[78:15];
        t = td[126:79];
        is_cmd = (id == ctl_id) && (len == CmdLen);
        if (is_cmd && !rec_on && (data == 64'(start_a) || data == 64'(start_b))) begin
            rec_on = 1'b1;
        end else if (is_cmd && rec_on && data == 64'(stop_c)) begin
            dump_sessions();
            clear_sessions();
            rec_on = 1'b0;
            return;
        end
        if (rec_on) log_frame(id, t);
    endtask

    always @(posedge i_clk) begin
        t_record e;
        if (!i_rst_n) begin
            ctl_id = RstControlId;
            start_a = RstStartA;
            start_b = RstStartB;
            stop_c = RstStop;
            rec_on = 1'b0;
            clear_sessions();
            expected_records.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_CONTROL_ID: ctl_id = i_cfg_data[IdW-1:0];
                    CFG_START_A:    start_a = i_cfg_data;
                    CFG_START_B:    start_b = i_cfg_data;
                    CFG_STOP:       stop_c = i_cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) predict_frame(s_axis_tdata);
            // Compare each accepted record with the oldest prediction.
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_records.size() == 0) begin
                    report_mismatch($sformatf("unexpected record id %0h", m_axis_tdata[10:0]));
                end else begin
                    e = expected_records.pop_front();
                    if (m_axis_tdata[10:0] !== e.id)
                        report_mismatch($sformatf("stat_id %0h exp %0h",
                                                  m_axis_tdata[10:0], e.id));
                    if (m_axis_tdata[42:11] !== e.count)
                        report_mismatch($sformatf("msg_count %0d exp %0d id %0h",
                                                  m_axis_tdata[42:11], e.count, e.id));
                    if (m_axis_tdata[97:43] !== e.mean)
                        report_mismatch($sformatf("mean_gap %0d exp %0d id %0h",
                                                  m_axis_tdata[97:43], e.mean, e.id));
                    if (m_axis_tuser[0] !== e.mean_ok)
                        report_mismatch($sformatf("mean_valid wrong id %0h", e.id));
                    if (m_axis_tuser[1] !== e.ovf)
                        report_mismatch($sformatf("table_overflow wrong id %0h", e.id));
                    if (m_axis_tlast !== e.last)
                        report_mismatch($sformatf("tlast wrong id %0h", e.id));
                end
            end
        end
    end

endmodule

### tb/can_session_id_rate_stats_test.sv
// Top of the testbench: clock, reset, frame stimulus, register phases and verdict.
`timescale 1ns / 100ps
module can_session_id_rate_stats_test;
    import csrs_pkg::*;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [InTdW-1:0]   s_axis_tdata = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [OutTdW-1:0]  m_axis_tdata;
    logic [OutTuW-1:0]  m_axis_tuser;
    logic               m_axis_tlast;
    logic               i_cfg_we = 1'b0;
    logic [CfgIdxW-1:0] i_cfg_index = '0;
    logic [CfgW-1:0]    i_cfg_data = '0;
    int                 fail_count;
    int                 pending;
    int                 frames_sent;
    int                 stall_left = 0;
    bit                 drain_stalls = 1'b1;

    // Current register values, so that commands can be built.
    logic [IdW-1:0]   ctl_id = RstControlId;
    logic [CodeW-1:0] start_a = RstStartA, start_b = RstStartB, stop_c = RstStop;
    logic [TimeW-1:0] now_ms;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    can_session_id_rate_stats u_top (.*);

    can_session_id_rate_stats_checker u_chk (
        .*,
        .o_fail_count(fail_count),
        .o_pending(pending)
    );

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Receiver stalls of random length, with long stall-free stretches.
    always @(posedge i_clk) begin
        if (!drain_stalls) begin
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end else if ($urandom_range(0, 99) < 35) begin
            m_axis_tready <= 1'b0;
            stall_left = gap_len();
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (frames_sent % 60 < 15) drain_stalls = 1'b0;
        else drain_stalls = 1'b1;
    end

    // Present one frame; tvalid stays high after acceptance when the next frame follows at once.
    task automatic send_frame(input logic [IdW-1:0] id, input logic [LenW-1:0] len,
                              input logic [DataW-1:0] data, input logic [TimeW-1:0] t);
        int g;
        g = (frames_sent % 50 < 10) ? 0 : gap_len();
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        s_axis_tdata <= {1'b0, t, data, len, id};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        frames_sent++;
    endtask

    task automatic send_ordinary(input logic [IdW-1:0] id);
        now_ms += $urandom_range(0, 9) == 0 ? 48'($urandom_range(0, 100000)) :
                  48'($urandom_range(0, 30));
        send_frame(id, 4'($urandom_range(0, 15)), {$urandom, $urandom}, now_ms);
    endtask

    task automatic start_session();
        send_frame(ctl_id, CmdLen, $urandom_range(0, 1) ? 64'(start_a) : 64'(start_b), now_ms);
    endtask

    task automatic stop_session();
        now_ms += 48'($urandom_range(0, 50));
        send_frame(ctl_id, CmdLen, 64'(stop_c), now_ms);
    endtask

    // Take the input idle and wait for every record, then for any dump still in flight.
    task automatic settle();
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (4500) @(posedge i_clk);
    endtask

    // Write enable stays high across back-to-back writes; end_writes drops it.
    task automatic write_reg(input t_cfg_idx idx, input logic [CfgW-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_CONTROL_ID: ctl_id = val[IdW-1:0];
            CFG_START_A:    start_a = val;
            CFG_START_B:    start_b = val;
            CFG_STOP:       stop_c = val;
            default: ;
        endcase
    endtask

    task automatic end_writes();
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // One session of random frames over a small id pool, with some noise.
    task automatic random_session(input int n_frames, input int pool);
        logic [IdW-1:0] ids [];
        ids = new[pool];
        foreach (ids[k]) ids[k] = 11'($urandom_range(0, 2047));
        start_session();
        repeat (n_frames) begin
            case ($urandom_range(0, 19))
                0: send_frame(ctl_id, CmdLen, 64'(start_a), now_ms);
                1: send_frame(ctl_id, CmdLen, 64'(stop_c) | (64'd1 << $urandom_range(16, 63)),
                              now_ms);
                2: send_frame(ctl_id, 4'($urandom_range(3, 15)), 64'(stop_c), now_ms);
                default: send_ordinary(ids[$urandom_range(0, pool - 1)]);
            endcase
        end
        stop_session();
    endtask

    initial begin
        now_ms = 0;
        frames_sent = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: stop while idle, noise while idle, start, extremes, overflow.
        send_frame(ctl_id, CmdLen, 64'(stop_c), 48'd5);
        send_frame(11'h7FF, 4'hF, '1, '1);
        send_frame(ctl_id, CmdLen, 64'(start_a), 48'd10);
        send_frame(11'h000, 4'd0, '0, 48'd20);
        send_frame(11'h000, 4'd8, '1, 48'd27);
        send_frame(11'h000, 4'd8, 64'h1, 48'd33);
        send_frame(11'h7FF, 4'hF, '1, 48'hFFFF_FFFF_FFFF);
        send_frame(11'h7FF, 4'd1, '0, 48'd0);
        send_frame(ctl_id, CmdLen, 64'(start_b), 48'd40);
        send_frame(ctl_id, CmdLen, 64'(stop_c) | (64'd1 << 63), 48'd41);
        send_frame(11'h123, 4'd3, 64'h55, 48'd50);
        send_frame(ctl_id, CmdLen, 64'(stop_c), 48'd60);
        // Session with start code b and a full table plus dropped ids.
        send_frame(ctl_id, CmdLen, 64'(start_b), 48'd100);
        for (int k = 0; k < 66; k++)
            send_frame(11'(k * 31 + 1), 4'($urandom_range(0, 8)), {$urandom, $urandom},
                       48'(200 + k));
        send_frame(11'd1, 4'd8, '0, 48'd500);
        send_frame(ctl_id, CmdLen, 64'(stop_c), 48'd600);
        settle();

        // Register phases: defaults, extremes, random values.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: ;
                1: begin
                    write_reg(CFG_CONTROL_ID, 16'h07FF);
                    write_reg(CFG_START_A, 16'hFFFF);
                    write_reg(CFG_START_B, 16'h0000);
                    write_reg(CFG_STOP, 16'h8000);
                end
                2: begin
                    write_reg(CFG_CONTROL_ID, 16'h0000);
                    write_reg(CFG_START_A, 16'h0000);
                    write_reg(CFG_START_B, 16'h7FFF);
                    write_reg(CFG_STOP, 16'hFFFF);
                end
                default: begin
                    write_reg(CFG_CONTROL_ID, 16'($urandom_range(0, 2047)));
                    write_reg(CFG_START_A, 16'($urandom));
                    write_reg(CFG_START_B, 16'($urandom));
                    write_reg(CFG_STOP, 16'($urandom));
                end
            endcase
            end_writes();
            repeat (3) random_session($urandom_range(10, 30), $urandom_range(1, 8));
            settle();
        end

        repeat (200) @(posedge i_clk);
        if (fail_count == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
